[hdl/cpu_t_state_bus_sequencer_defines.svh]
// assertion macros shared by the sequencer rtl
`ifndef CPU_T_STATE_BUS_SEQUENCER_DEFINES_SVH
`define CPU_T_STATE_BUS_SEQUENCER_DEFINES_SVH

// condition on this edge implies consequence on the same edge
`define CTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition on this edge implies consequence on the next edge
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cts_seq_pkg.sv]
package cts_seq_pkg;

    // sequencer step, t_step on the output bus carries its code
    typedef enum logic [3:0] {
        ST_FETCH_T1 = 4'd0,
        ST_FETCH_T2 = 4'd1,
        ST_FETCH_T3 = 4'd2,
        ST_FETCH_T4 = 4'd3,
        ST_MEM1_T1  = 4'd4,
        ST_MEM1_T2  = 4'd5,
        ST_MEM1_T3  = 4'd6,
        ST_MEM2_T1  = 4'd7,
        ST_MEM2_T2  = 4'd8,
        ST_MEM2_T3  = 4'd9
    } t_step;

    // opcodes handled by the sequencer
    localparam logic [7:0] OP_LD_BC_NN = 8'h01;
    localparam logic [7:0] OP_LD_BC_A  = 8'h02;
    localparam logic [7:0] OP_INC_BC   = 8'h03;
    localparam logic [7:0] OP_INC_B    = 8'h04;
    localparam logic [7:0] OP_DEC_B    = 8'h05;
    localparam logic [7:0] OP_LD_B_N   = 8'h06;
    localparam logic [7:0] OP_RLCA     = 8'h07;
    localparam logic [7:0] OP_EX_AF    = 8'h08;

    // strobe vector bit positions, all active low
    localparam int SB_M1   = 0;
    localparam int SB_MREQ = 1;
    localparam int SB_RD   = 2;
    localparam int SB_WR   = 3;
    localparam int SB_RFSH = 4;

    // flag bit positions
    localparam int FL_S  = 7;
    localparam int FL_Z  = 6;
    localparam int FL_H  = 4;
    localparam int FL_PV = 2;
    localparam int FL_N  = 1;
    localparam int FL_C  = 0;

    // flag bits that survive the swap from the shadow pair
    localparam logic [7:0] FL_SHADOW_MASK = 8'hD7;

endpackage

[hdl/cpu_t_state_bus_sequencer.sv]
// channel  | dir | tdata fields, lowest bit first
// ---------+-----+-------------------------------------------------------------
// s stream | in  | clk_high[0] wait_n[1] data_in[9:2], zero pad to 16
// m stream | out | address[15:0] data_out[23:16] m1_n[24] mreq_n[25] rd_n[26]
//          |     | wr_n[27] rfsh_n[28] t_step[32:29] mcycle_count[40:33]
//          |     | reg_a[48:41] reg_bc[64:49] flags_out[72:65], zero pad to 80
//
// one transfer per cycle unless stalled: each bus phase is worked out from the
// architectural registers, which are themselves the result register
// a new phase is taken whenever the result slot is empty or being drained
// a stall on the m side holds the s side, so no phase is ever skipped
// synchronous active-low reset clears all but the strobes, which go inactive
`include "cpu_t_state_bus_sequencer_defines.svh"

module cpu_t_state_bus_sequencer
    import cts_seq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // clk_high, wait_n, data_in[7:0], pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // address, data_out, m1_n, mreq_n, rd_n,
                                     // wr_n, rfsh_n, t_step, mcycle_count,
                                     // reg_a, reg_bc, flags_out, pad
);

    // architectural and bus registers
    t_step       r_step,   n_step;
    logic [15:0] r_pc,     n_pc;
    logic [7:0]  r_acc,    n_acc;
    logic [7:0]  r_flags,  n_flags;
    logic [7:0]  r_b,      n_b;
    logic [7:0]  r_c,      n_c;
    logic [15:0] r_shadow, n_shadow;
    logic [15:0] r_ir,     n_ir;
    logic [7:0]  r_op,     n_op;
    logic [7:0]  r_cycle,  n_cycle;
    logic [15:0] r_addr,   n_addr;
    logic [7:0]  r_dout,   n_dout;
    logic [4:0]  r_strobe, n_strobe;
    logic        r_out_valid;

    logic       in_xfer;
    logic       hi;
    logic       wait_act;
    logic [7:0] din;
    logic       rd_op;
    logic [7:0] inc_res;
    logic [7:0] dec_res;
    logic [6:0] ir_low_inc;

    // handshake
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    // unpack the phase
    assign hi       = i_s_tdata[0];
    assign wait_act = !i_s_tdata[1];
    assign din      = i_s_tdata[9:2];
    assign rd_op    = (r_op == OP_LD_BC_NN) || (r_op == OP_LD_B_N);

    assign inc_res    = r_b + 8'd1;
    assign dec_res    = r_b - 8'd1;
    assign ir_low_inc = r_ir[6:0] + 7'd1;

    // next step
    always_comb begin
        n_step = r_step;
        case (r_step)
            ST_FETCH_T1: begin
                if (!hi) n_step = ST_FETCH_T2;
            end
            ST_FETCH_T2: begin
                if (!hi && !wait_act) n_step = ST_FETCH_T3;
            end
            ST_FETCH_T3: begin
                if (!hi) n_step = ST_FETCH_T4;
            end
            ST_FETCH_T4: begin
                if (!hi) begin
                    if (rd_op || r_op == OP_LD_BC_A || r_op == OP_INC_BC) begin
                        n_step = ST_MEM1_T1;
                    end else begin
                        n_step = ST_FETCH_T1;
                    end
                end
            end
            ST_MEM1_T1: begin
                if (rd_op || r_op == OP_LD_BC_A || r_op == OP_INC_BC) begin
                    if (!hi) n_step = ST_MEM1_T2;
                end else begin
                    n_step = ST_FETCH_T1;
                end
            end
            ST_MEM1_T2: begin
                if (rd_op || r_op == OP_LD_BC_A) begin
                    if (!hi && !wait_act) n_step = ST_MEM1_T3;
                end else if (r_op == OP_INC_BC) begin
                    if (!hi) n_step = ST_FETCH_T1;
                end else begin
                    n_step = ST_FETCH_T1;
                end
            end
            ST_MEM1_T3: begin
                if (rd_op || r_op == OP_LD_BC_A) begin
                    if (!hi) begin
                        n_step = (r_op == OP_LD_BC_NN) ? ST_MEM2_T1 : ST_FETCH_T1;
                    end
                end else begin
                    n_step = ST_FETCH_T1;
                end
            end
            ST_MEM2_T1: begin
                if (r_op == OP_LD_BC_NN) begin
                    if (!hi) n_step = ST_MEM2_T2;
                end else begin
                    n_step = ST_FETCH_T1;
                end
            end
            ST_MEM2_T2: begin
                if (r_op == OP_LD_BC_NN) begin
                    if (!hi && !wait_act) n_step = ST_MEM2_T3;
                end else begin
                    n_step = ST_FETCH_T1;
                end
            end
            ST_MEM2_T3: begin
                if (r_op == OP_LD_BC_NN) begin
                    if (!hi) n_step = ST_FETCH_T1;
                end else begin
                    n_step = ST_FETCH_T1;
                end
            end
            default: n_step = ST_FETCH_T1;
        endcase
    end

    // bus strobes, address and register updates
    always_comb begin
        n_pc     = r_pc;
        n_acc    = r_acc;
        n_flags  = r_flags;
        n_b      = r_b;
        n_c      = r_c;
        n_shadow = r_shadow;
        n_ir     = r_ir;
        n_op     = r_op;
        n_cycle  = r_cycle;
        n_addr   = r_addr;
        n_dout   = r_dout;
        n_strobe = r_strobe;
        case (r_step)
            ST_FETCH_T1: begin
                if (hi) begin
                    n_addr = r_pc;
                    n_strobe[SB_M1] = 1'b0;
                end else begin
                    n_strobe[SB_MREQ] = 1'b0;
                    n_strobe[SB_RD]   = 1'b0;
                end
            end
            ST_FETCH_T2: begin
                if (!hi && !wait_act) n_op = din;
            end
            ST_FETCH_T3: begin
                if (hi) begin
                    n_addr = r_ir;
                    n_strobe[SB_MREQ] = 1'b1;
                    n_strobe[SB_RD]   = 1'b1;
                    n_strobe[SB_M1]   = 1'b1;
                    n_strobe[SB_RFSH] = 1'b0;
                end else begin
                    n_strobe[SB_MREQ] = 1'b0;
                end
            end
            ST_FETCH_T4: begin
                if (hi) begin
                    n_pc = r_pc + 16'd1;
                    n_ir = {r_ir[15:7], ir_low_inc};
                end else begin
                    // end of the opcode fetch, ops that need no further machine cycle retire here
                    n_strobe[SB_MREQ] = 1'b1;
                    n_strobe[SB_RFSH] = 1'b1;
                    n_cycle = r_cycle + 8'd1;
                    case (r_op)
                        OP_INC_B: begin
                            n_b = inc_res;
                            n_flags = '0;
                            n_flags[FL_S]  = inc_res[7];
                            n_flags[FL_Z]  = (inc_res == 8'd0);
                            n_flags[FL_H]  = (r_b[3:0] == 4'hF);
                            n_flags[FL_PV] = (r_b == 8'h7F);
                            n_flags[FL_C]  = r_flags[FL_C];
                        end
                        OP_DEC_B: begin
                            n_b = dec_res;
                            n_flags = '0;
                            n_flags[FL_S]  = dec_res[7];
                            n_flags[FL_Z]  = (dec_res == 8'd0);
                            n_flags[FL_H]  = (r_b[3:0] == 4'h0);
                            n_flags[FL_PV] = (r_b == 8'h80);
                            n_flags[FL_N]  = 1'b1;
                            n_flags[FL_C]  = r_flags[FL_C];
                        end
                        OP_RLCA: begin
                            n_acc = {r_acc[6:0], r_acc[7]};
                            n_flags = '0;
                            n_flags[FL_S]  = r_flags[FL_S];
                            n_flags[FL_Z]  = r_flags[FL_Z];
                            n_flags[FL_PV] = r_flags[FL_PV];
                            n_flags[FL_C]  = r_acc[7];
                        end
                        OP_EX_AF: begin
                            n_acc    = r_shadow[15:8];
                            n_flags  = r_shadow[7:0] & FL_SHADOW_MASK;
                            n_shadow = {r_acc, r_flags};
                        end
                        default: ;
                    endcase
                end
            end
            ST_MEM1_T1: begin
                if (rd_op) begin
                    if (hi) begin
                        n_addr = r_pc;
                    end else begin
                        n_strobe[SB_MREQ] = 1'b0;
                        n_strobe[SB_RD]   = 1'b0;
                    end
                end else if (r_op == OP_LD_BC_A) begin
                    if (hi) begin
                        n_addr = {r_b, r_c};
                    end else begin
                        n_dout = r_acc;
                        n_strobe[SB_MREQ] = 1'b0;
                    end
                end else if (r_op == OP_INC_BC) begin
                    if (hi) n_c = r_c + 8'd1;
                end
            end
            ST_MEM1_T2: begin
                if (r_op == OP_LD_BC_A) begin
                    if (!hi && !wait_act) n_strobe[SB_WR] = 1'b0;
                end else if (r_op == OP_INC_BC) begin
                    if (hi) begin
                        if (r_c == 8'd0) n_b = r_b + 8'd1;
                    end else begin
                        n_cycle = r_cycle + 8'd1;
                    end
                end
            end
            ST_MEM1_T3: begin
                if (rd_op) begin
                    if (!hi) begin
                        if (r_op == OP_LD_BC_NN) n_c = din;
                        else                     n_b = din;
                        n_strobe[SB_MREQ] = 1'b1;
                        n_strobe[SB_RD]   = 1'b1;
                        n_pc    = r_pc + 16'd1;
                        n_cycle = r_cycle + 8'd1;
                    end
                end else if (r_op == OP_LD_BC_A) begin
                    if (!hi) begin
                        n_strobe[SB_MREQ] = 1'b1;
                        n_strobe[SB_WR]   = 1'b1;
                        n_cycle = r_cycle + 8'd1;
                    end
                end
            end
            ST_MEM2_T1: begin
                if (r_op == OP_LD_BC_NN) begin
                    if (hi) begin
                        n_addr = r_pc;
                    end else begin
                        n_strobe[SB_MREQ] = 1'b0;
                        n_strobe[SB_RD]   = 1'b0;
                    end
                end
            end
            ST_MEM2_T3: begin
                if (r_op == OP_LD_BC_NN && !hi) begin
                    n_b = din;
                    n_strobe[SB_MREQ] = 1'b1;
                    n_strobe[SB_RD]   = 1'b1;
                    n_pc    = r_pc + 16'd1;
                    n_cycle = r_cycle + 8'd1;
                end
            end
            default: ;
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_FETCH_T1;
            r_pc        <= '0;
            r_acc       <= '0;
            r_flags     <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_shadow    <= '0;
            r_ir        <= '0;
            r_op        <= '0;
            r_cycle     <= '0;
            r_addr      <= '0;
            r_dout      <= '0;
            r_strobe    <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_step   <= n_step;
                r_pc     <= n_pc;
                r_acc    <= n_acc;
                r_flags  <= n_flags;
                r_b      <= n_b;
                r_c      <= n_c;
                r_shadow <= n_shadow;
                r_ir     <= n_ir;
                r_op     <= n_op;
                r_cycle  <= n_cycle;
                r_addr   <= n_addr;
                r_dout   <= n_dout;
                r_strobe <= n_strobe;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result bus
    assign o_m_tdata = {7'd0, r_flags, r_b, r_c, r_acc, r_cycle, r_step,
                        r_strobe[SB_RFSH], r_strobe[SB_WR], r_strobe[SB_RD],
                        r_strobe[SB_MREQ], r_strobe[SB_M1], r_dout, r_addr};

    // checks
    `CTS_ASSERT_SAME(a_wr_only_in_write, i_clk, i_rst_n,
        !r_strobe[SB_WR], r_step == ST_MEM1_T3,
        "write strobe active outside the write cycle")
    `CTS_ASSERT_SAME(a_rfsh_outside_m1, i_clk, i_rst_n,
        !r_strobe[SB_RFSH], r_strobe[SB_M1] && r_strobe[SB_RD],
        "refresh overlaps fetch strobes")
    `CTS_ASSERT_NEXT(a_hold_without_xfer, i_clk, i_rst_n,
        !in_xfer, $stable(r_step) && $stable(r_cycle) && $stable(r_strobe),
        "state moved without a transfer")
    `CTS_ASSERT_NEXT(a_cycle_step_one, i_clk, i_rst_n,
        in_xfer, (r_cycle == $past(r_cycle)) || (r_cycle == $past(r_cycle) + 8'd1),
        "machine cycle count jumped")
    `CTS_ASSERT_NEXT(a_result_after_xfer, i_clk, i_rst_n,
        in_xfer, o_m_tvalid,
        "transfer taken without a result")

endmodule
